/* rtl/gcmap_pkg.sv */
// ----------------------------------------------------------------------------
// gcmap_pkg
// Shared types, constants and the divider step for the gradient colormap.
// ----------------------------------------------------------------------------
package gcmap_pkg;

	localparam int NUM_STOPS = 8;
	localparam int REG_COUNT = 8;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int PADDR_W   = REG_IDX_W + 2;
	localparam int CH_COUNT  = 3;

	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	// numerator 2*num + d, num <= 255*255
	localparam int NUM_W = 17;
	localparam int DEN_W = 9;

	typedef logic [7:0] chan_t;
	typedef logic [CH_COUNT-1:0][7:0] rgb_t;
	typedef logic [NUM_W-1:0] num_t;
	typedef logic [DEN_W-1:0] den_t;

	typedef struct packed {
		chan_t idx;
		rgb_t  rgb;
	} stop_t;

	localparam stop_t STOP_FIRST_RST = 32'h0000_0000;
	localparam stop_t STOP_OTHER_RST = 32'hFFFF_FFFF;

	typedef struct packed {
		num_t rem;
		logic qbit;
	} div_step_t;

	// one restoring-division step against a pre-shifted divisor
	function automatic div_step_t div_step(num_t rem, num_t dsh);
		div_step_t r;
		if (rem >= dsh) begin
			r.rem  = rem - dsh;
			r.qbit = 1'b1;
		end else begin
			r.rem  = rem;
			r.qbit = 1'b0;
		end
		return r;
	endfunction

endpackage

/* rtl/gcmap_ifs.sv */
// ----------------------------------------------------------------------------
// gcmap_in_if / gcmap_out_if
// Valid/ready item channels: intensity in, RGB color out.
// ----------------------------------------------------------------------------
interface gcmap_in_if import gcmap_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t intensity;

	modport source (output valid, output intensity, input ready);
	modport sink (input valid, input intensity, output ready);
endinterface

interface gcmap_out_if import gcmap_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t red;
	chan_t green;
	chan_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

/* rtl/gradient_colormap_core.sv */
// ----------------------------------------------------------------------------
// gradient_colormap_core
// Piecewise-linear colormap: 8-bit intensity to RGB over up to eight stops.
// ----------------------------------------------------------------------------
// Takes one intensity per clock while the pipeline is not stalled and returns
// one color per item, in order. Stage 1 finds the enclosing segment, stage 2
// forms the products, stage 3 the rounded numerator, and stages 4 to 7 divide
// by the segment length two quotient bits per stage. Each stage holds on a
// stall and bubbles close up, so the input keeps being taken while a finished
// color waits at the output, until every stage is full. Stops are APB
// registers at byte address 4*i (index 31:24, red 23:16, green 15:8, blue
// 7:0), written in ascending index order while the block is idle.
// ----------------------------------------------------------------------------
module gradient_colormap_core import gcmap_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	gcmap_in_if.sink           pix_in,
	gcmap_out_if.source        pix_out
);

	stop_t stop_q [REG_COUNT];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	rgb_t  c0_s1, c1_s1;
	chan_t off_s1, d_s1;

	logic [15:0]        pa_s2 [CH_COUNT];
	logic signed [17:0] pb_s2 [CH_COUNT];
	chan_t              d_s2;

	num_t n_s3 [CH_COUNT];
	den_t den_s3, den_s4, den_s5, den_s6;

	num_t rem_s4 [CH_COUNT], rem_s5 [CH_COUNT], rem_s6 [CH_COUNT], rem_s7 [CH_COUNT];
	logic [1:0] q_s4 [CH_COUNT];
	logic [3:0] q_s5 [CH_COUNT];
	logic [5:0] q_s6 [CH_COUNT];
	logic [7:0] q_s7 [CH_COUNT];

	// config registers
	assign pready = 1'b1;
	assign prdata = stop_q[paddr[PADDR_W-1:2]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < REG_COUNT; k++) begin
				stop_q[k] <= (k == 0) ? STOP_FIRST_RST : STOP_OTHER_RST;
			end
		end else if (psel && penable && pwrite) begin
			stop_q[paddr[PADDR_W-1:2]] <= stop_t'(pwdata);
		end
	end

	// handshake: a stage loads when empty or when its successor moves
	assign rdy7 = !v_s7 || pix_out.ready;
	assign rdy6 = !v_s6 || rdy7;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign pix_in.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pix_in.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
		end
	end

	// stage 1: segment search
	stop_t lo, hi;
	logic  const_sel;
	chan_t seg_d, x;

	assign x = pix_in.intensity;

	always_comb begin
		lo        = stop_q[0];
		hi        = stop_q[0];
		const_sel = 1'b1;
		// later segments win at shared ends
		for (int s = 0; s < NUM_STOPS - 1; s++) begin
			if (stop_q[s].idx <= x && x <= stop_q[s+1].idx) begin
				lo        = stop_q[s];
				hi        = stop_q[s+1];
				const_sel = 1'b0;
			end
		end
		priority if (x > stop_q[NUM_STOPS-1].idx) begin
			lo        = stop_q[NUM_STOPS-1];
			hi        = stop_q[NUM_STOPS-1];
			const_sel = 1'b1;
		end else if (x < stop_q[0].idx) begin
			lo        = stop_q[0];
			hi        = stop_q[0];
			const_sel = 1'b1;
		end else begin
		end
		seg_d = hi.idx - lo.idx;
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			c0_s1  <= lo.rgb;
			c1_s1  <= const_sel ? lo.rgb : hi.rgb;
			off_s1 <= const_sel ? 8'd0 : x - lo.idx;
			d_s1   <= (const_sel || seg_d == 8'd0) ? 8'd1 : seg_d;
		end
	end

	// stage 2: c0*d and off*(c1-c0)
	logic signed [8:0] diff [CH_COUNT];

	always_comb begin
		for (int ch = 0; ch < CH_COUNT; ch++) begin
			diff[ch] = $signed({1'b0, c1_s1[ch]}) - $signed({1'b0, c0_s1[ch]});
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			for (int ch = 0; ch < CH_COUNT; ch++) begin
				pa_s2[ch] <= {8'd0, c0_s1[ch]} * {8'd0, d_s1};
				pb_s2[ch] <= $signed({10'd0, off_s1}) * diff[ch];
			end
			d_s2 <= d_s1;
		end
	end

	// stage 3: rounded numerator 2*num + d over divisor 2*d
	logic signed [17:0] sum [CH_COUNT];
	logic [15:0]        num [CH_COUNT];

	always_comb begin
		for (int ch = 0; ch < CH_COUNT; ch++) begin
			sum[ch] = $signed({2'b00, pa_s2[ch]}) + pb_s2[ch];
			num[ch] = sum[ch][17] ? 16'd0 : sum[ch][15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			for (int ch = 0; ch < CH_COUNT; ch++) begin
				n_s3[ch] <= {num[ch], 1'b0} + {9'd0, d_s2};
			end
			den_s3 <= {d_s2, 1'b0};
		end
	end

	// stages 4..7: restoring divide, two quotient bits per stage
	div_step_t ha4 [CH_COUNT], hb4 [CH_COUNT], ha5 [CH_COUNT], hb5 [CH_COUNT];
	div_step_t ha6 [CH_COUNT], hb6 [CH_COUNT], ha7 [CH_COUNT], hb7 [CH_COUNT];

	always_comb begin
		for (int ch = 0; ch < CH_COUNT; ch++) begin
			ha4[ch] = div_step(n_s3[ch], num_t'(den_s3) << 7);
			hb4[ch] = div_step(ha4[ch].rem, num_t'(den_s3) << 6);
			ha5[ch] = div_step(rem_s4[ch], num_t'(den_s4) << 5);
			hb5[ch] = div_step(ha5[ch].rem, num_t'(den_s4) << 4);
			ha6[ch] = div_step(rem_s5[ch], num_t'(den_s5) << 3);
			hb6[ch] = div_step(ha6[ch].rem, num_t'(den_s5) << 2);
			ha7[ch] = div_step(rem_s6[ch], num_t'(den_s6) << 1);
			hb7[ch] = div_step(ha7[ch].rem, num_t'(den_s6));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			for (int ch = 0; ch < CH_COUNT; ch++) begin
				rem_s4[ch] <= hb4[ch].rem;
				q_s4[ch]   <= {ha4[ch].qbit, hb4[ch].qbit};
			end
			den_s4 <= den_s3;
		end
		if (rdy5) begin
			for (int ch = 0; ch < CH_COUNT; ch++) begin
				rem_s5[ch] <= hb5[ch].rem;
				q_s5[ch]   <= {q_s4[ch], ha5[ch].qbit, hb5[ch].qbit};
			end
			den_s5 <= den_s4;
		end
		if (rdy6) begin
			for (int ch = 0; ch < CH_COUNT; ch++) begin
				rem_s6[ch] <= hb6[ch].rem;
				q_s6[ch]   <= {q_s5[ch], ha6[ch].qbit, hb6[ch].qbit};
			end
			den_s6 <= den_s5;
		end
		if (rdy7) begin
			for (int ch = 0; ch < CH_COUNT; ch++) begin
				rem_s7[ch] <= hb7[ch].rem;
				q_s7[ch]   <= {q_s6[ch], ha7[ch].qbit, hb7[ch].qbit};
			end
		end
	end

	assign pix_out.valid = v_s7;
	assign pix_out.red   = q_s7[CH_RED];
	assign pix_out.green = q_s7[CH_GREEN];
	assign pix_out.blue  = q_s7[CH_BLUE];

`ifndef SYNTHESIS
	logic n_in_range;
	logic rem_zero_ok;

	always_comb begin
		n_in_range  = 1'b1;
		rem_zero_ok = 1'b1;
		for (int ch = 0; ch < CH_COUNT; ch++) begin
			if (n_s3[ch] >= {den_s3, 8'd0}) n_in_range = 1'b0;
			if (rem_s7[ch] > num_t'(16'hFFFF)) rem_zero_ok = 1'b0;
		end
	end

	// quotient must fit in eight bits
	a_num_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> n_in_range)
		else $error("numerator exceeds 256 times divisor");

	a_clamp_const: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_in.valid && pix_in.ready && pix_in.intensity > stop_q[NUM_STOPS-1].idx)
		|=> (off_s1 == 8'd0 && c0_s1 == c1_s1 && d_s1 == 8'd1))
		else $error("above-last intensity not mapped to a flat color");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> d_s1 != 8'd0)
		else $error("zero segment length reached the divider");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> rem_zero_ok)
		else $error("divider remainder out of range");
`endif

endmodule

/* dv/gcmap_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gcmap_checker
// Tracks the stop registers from APB writes and predicts the color of each
// accepted intensity. Every color leaving the core is compared channel by
// channel, in order, with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module gcmap_checker import gcmap_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	gcmap_in_if                pix_in,
	gcmap_out_if               pix_out,
	output int                 mismatches,
	output int                 pending
);

	typedef struct {
		chan_t x;
		rgb_t  color;
	} color_due_t;

	stop_t      stop_q [REG_COUNT];
	color_due_t colors_due [$];
	int         fail_total = 0;
	int         due_total  = 0;

	assign mismatches = fail_total;
	assign pending    = due_total;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		fail_total++;
	endtask

	// round(c0 + off*(c1-c0)/span), halves away from zero; acc is never negative here
	function automatic chan_t blend(chan_t c0, chan_t c1, int off, int span);
		int acc;
		if (span == 0) begin
			return c0;
		end
		acc = int'(c0) * span + off * (int'(c1) - int'(c0));
		if (acc < 0) begin
			acc = 0;
		end
		return chan_t'((acc * 2 + span) / (2 * span));
	endfunction

	function automatic rgb_t predict_color(chan_t x);
		rgb_t color;
		int   pick;
		int   seg;
		pick = -1;
		seg  = -1;
		if (x > stop_q[NUM_STOPS-1].idx) begin
			pick = NUM_STOPS - 1;
		end else if (x < stop_q[0].idx) begin
			pick = 0;
		end else begin
			for (int s = NUM_STOPS - 2; s >= 0; s--) begin
				if (stop_q[s].idx <= x && x <= stop_q[s+1].idx) begin
					seg = s;
					break;
				end
			end
			if (seg < 0) begin
				pick = 0;
			end
		end
		for (int ch = 0; ch < CH_COUNT; ch++) begin
			if (pick >= 0) begin
				color[ch] = stop_q[pick].rgb[ch];
			end else begin
				color[ch] = blend(stop_q[seg].rgb[ch], stop_q[seg+1].rgb[ch],
					int'(x) - int'(stop_q[seg].idx),
					int'(stop_q[seg+1].idx) - int'(stop_q[seg].idx));
			end
		end
		return color;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_t       got;
		color_due_t want;
		color_due_t due;
		if (!arst_n) begin
			stop_q[0] <= STOP_FIRST_RST;
			for (int k = 1; k < REG_COUNT; k++) begin
				stop_q[k] <= STOP_OTHER_RST;
			end
			colors_due.delete();
			due_total = 0;
		end else begin
			if (pix_out.valid && pix_out.ready) begin
				got = {pix_out.red, pix_out.green, pix_out.blue};
				if (colors_due.size() == 0) begin
					report_mismatch($sformatf("color %h with no item outstanding", got));
				end else begin
					want = colors_due.pop_front();
					for (int ch = 0; ch < CH_COUNT; ch++) begin
						if (got[ch] !== want.color[ch]) begin
							report_mismatch($sformatf("intensity %h: %s got %h want %h",
								want.x,
								ch == CH_RED ? "red" : (ch == CH_GREEN ? "green" : "blue"),
								got[ch], want.color[ch]));
						end
					end
				end
			end
			if (pix_in.valid && pix_in.ready) begin
				due.x     = pix_in.intensity;
				due.color = predict_color(pix_in.intensity);
				colors_due.insert(colors_due.size(), due);
			end
			if (psel && penable && pwrite && pready && (paddr >> 2) < REG_COUNT) begin
				stop_q[paddr[PADDR_W-1:2]] <= stop_t'(pwdata);
			end
			due_total = colors_due.size();
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for gradient_colormap_core: programs the eight color stops over
// APB, runs directed corner intensities (ends, joints, zero-length segments,
// unsorted stops), then random stop sets and intensities under changing
// backpressure. Checking is done by gcmap_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import gcmap_pkg::*;

	localparam int PHASES     = 11;
	localparam int PHASE_ITEMS = 103;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [31:0]        pwdata  = '0;
	logic [31:0]        prdata;
	logic               pready;

	int    src_idle_pct = 14;
	int    snk_idle_pct = 81;
	int    mismatches;
	int    pending;
	stop_t cur_stops [REG_COUNT];

	gcmap_in_if  pix_in ();
	gcmap_out_if pix_out ();

	gradient_colormap_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

	gcmap_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.pix_in     (pix_in),
		.pix_out    (pix_out),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		pix_out.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	task automatic write_reg(input int idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx << 2);
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_stops();
		for (int k = 0; k < REG_COUNT; k++) begin
			write_reg(k, cur_stops[k]);
		end
	endtask

	task automatic send_pixel(input chan_t x);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in.valid     <= 1'b1;
		pix_in.intensity <= x;
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		pix_in.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		@(negedge clk);
	endtask

	// ascending stop set, unused stops repeat the last one
	task automatic make_ramp();
		int n;
		int base;
		int marks [$];
		n    = $urandom_range(2, NUM_STOPS);
		base = $urandom_range(252);
		for (int k = 0; k < n; k++) begin
			marks.insert(marks.size(), $urandom_range(3) == 0 ? base + $urandom_range(3)
				: $urandom_range(255));
		end
		marks.sort();
		if ($urandom_range(1)) marks[0] = 0;
		if ($urandom_range(1)) marks[n-1] = 255;
		for (int k = 0; k < REG_COUNT; k++) begin
			if (k < n) begin
				cur_stops[k] = stop_t'({8'(marks[k]), 24'($urandom())});
			end else begin
				cur_stops[k] = cur_stops[n-1];
			end
		end
	endtask

	// biased toward stop indices so joints and ends get hit often
	function automatic chan_t pick_intensity();
		int v;
		if ($urandom_range(9) < 4) begin
			v = int'(cur_stops[$urandom_range(REG_COUNT-1)].idx) + int'($urandom_range(2)) - 1;
			if (v < 0) v = 0;
			if (v > 255) v = 255;
		end else begin
			v = $urandom_range(255);
		end
		return chan_t'(v);
	endfunction

	initial begin
		logic [31:0] joint_set [REG_COUNT] = '{
			32'h10_00FF80, 32'h40_FF0001, 32'h40_20E07F, 32'h80_FFFF00,
			32'hC0_0000FF, 32'hF0_817E33, 32'hF0_817E33, 32'hF0_817E33};
		logic [31:0] unsorted_set [REG_COUNT] = '{
			32'h80_112233, 32'h20_FFEEDD, 32'hC0_000000, 32'h10_FFFFFF,
			32'hFF_808080, 32'h30_0A0B0C, 32'h90_F00F0F, 32'hE0_55AA55};
		chan_t gray_x [6]      = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
		chan_t joint_x [12]    = '{8'h00, 8'h0F, 8'h10, 8'h11, 8'h3F, 8'h40,
			8'h41, 8'h60, 8'h9F, 8'hF0, 8'hF1, 8'hFF};
		chan_t unsorted_x [7]  = '{8'h00, 8'h7F, 8'h80, 8'h85, 8'hA0, 8'hE0, 8'hE1};

		pix_in.valid     = 1'b0;
		pix_in.intensity = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset map is a gray ramp
		foreach (gray_x[i]) send_pixel(gray_x[i]);
		drain();
		foreach (joint_set[k]) cur_stops[k] = stop_t'(joint_set[k]);
		load_stops();
		foreach (joint_x[i]) send_pixel(joint_x[i]);
		drain();
		foreach (unsorted_set[k]) cur_stops[k] = stop_t'(unsorted_set[k]);
		load_stops();
		foreach (unsorted_x[i]) send_pixel(unsorted_x[i]);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph == 4) begin
				src_idle_pct = 81;
				snk_idle_pct = 14;
			end else if (ph == 8) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			if (ph == 1) begin
				foreach (cur_stops[k]) cur_stops[k] = stop_t'(32'h0000_0000);
			end else if (ph == 5) begin
				foreach (cur_stops[k]) cur_stops[k] = stop_t'(32'hFFFF_FFFF);
			end else if (ph % 4 == 3) begin
				foreach (cur_stops[k]) cur_stops[k] = stop_t'($urandom());
			end else begin
				make_ramp();
			end
			load_stops();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_pixel(pick_intensity());
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
